[src/evg_pkg.sv]
// Shared types, constants and helpers for the ellipse vertex generator.
package evg_pkg;

	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;
	localparam int COORD_W = 32;
	localparam int RAD_W   = 31;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int TURN_W  = 32;
	localparam int XY_W    = 34;
	localparam int TRIG_W  = 32;

	localparam int CORDIC_STEPS = 28;
	localparam logic [XY_W-1:0] CORDIC_GAIN = XY_W'(32'h26DD3B6A);

	localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	localparam logic [RAD_W-1:0] MAJOR_RESET = RAD_W'(65536);
	localparam logic [RAD_W-1:0] MINOR_RESET = RAD_W'(32768);
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(21);

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_MAJOR_RADIUS,
		REG_MINOR_RADIUS,
		REG_VERTEX_COUNT
	} evg_reg_t;

	typedef enum logic [1:0] {
		QUAD_EAST,
		QUAD_NORTH,
		QUAD_WEST,
		QUAD_SOUTH
	} evg_quad_t;

	typedef struct packed {
		logic valid;
		logic err;
		logic zero_ang;
	} evg_tag_t;

	localparam int SUM_W = COORD_W + 3;

	function automatic logic [COORD_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(33'sh0_7FFF_FFFF);
		lo = -SUM_W'(33'sh0_8000_0000);
		if (v > hi) begin
			saturate = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < lo) begin
			saturate = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			saturate = v[COORD_W-1:0];
		end
	endfunction

endpackage

[src/evg_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for the turn fraction.
module evg_divider #(
	parameter int ANGLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  evg_pkg::evg_tag_t             in_tag,
	input  logic [evg_pkg::IDX_W-1:0]     in_index,
	input  logic [evg_pkg::CNT_W-1:0]     in_div,
	output evg_pkg::evg_tag_t             out_tag,
	output logic [ANGLE_BITS-1:0]         out_quot
);
	import evg_pkg::*;

	localparam int STAGES = ANGLE_BITS + 1;

	evg_tag_t              tag_s  [STAGES];
	logic [CNT_W-1:0]      rem_s  [STAGES];
	logic [CNT_W-1:0]      div_s  [STAGES];
	logic [ANGLE_BITS-1:0] low_s  [STAGES];
	logic [ANGLE_BITS-1:0] quot_s [STAGES];

	evg_tag_t              tag_in  [STAGES];
	logic [CNT_W-1:0]      rem_in  [STAGES];
	logic [CNT_W-1:0]      div_in  [STAGES];
	logic                  bit_in  [STAGES];
	logic [CNT_W:0]        trial   [STAGES];
	logic                  q_bit   [STAGES];
	logic [CNT_W-1:0]      rem_nx  [STAGES];
	logic [ANGLE_BITS-1:0] low_nx  [STAGES];
	logic [ANGLE_BITS-1:0] quot_nx [STAGES];

	always_comb begin
		tag_in[0]  = in_tag;
		rem_in[0]  = CNT_W'(in_index[IDX_W-1:1]);
		div_in[0]  = in_div;
		bit_in[0]  = in_index[0];
		low_nx[0]  = ANGLE_BITS'(in_div[CNT_W-1:1]);
		for (int k = 1; k < STAGES; k++) begin
			tag_in[k] = tag_s[k-1];
			rem_in[k] = rem_s[k-1];
			div_in[k] = div_s[k-1];
			bit_in[k] = low_s[k-1][ANGLE_BITS-1];
			low_nx[k] = low_s[k-1] << 1;
		end
		for (int k = 0; k < STAGES; k++) begin
			trial[k]  = {rem_in[k], bit_in[k]};
			q_bit[k]  = (trial[k] >= {1'b0, div_in[k]});
			rem_nx[k] = q_bit[k] ? CNT_W'(trial[k] - {1'b0, div_in[k]})
			                     : trial[k][CNT_W-1:0];
		end
		quot_nx[0] = '0;
		for (int k = 1; k < STAGES; k++) begin
			quot_nx[k] = {quot_s[k-1][ANGLE_BITS-2:0], q_bit[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				tag_s[k] <= '0;
			end
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				tag_s[k] <= tag_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			rem_s[k]  <= rem_nx[k];
			div_s[k]  <= div_in[k];
			low_s[k]  <= low_nx[k];
			quot_s[k] <= quot_nx[k];
		end
	end

	assign out_tag  = tag_s[STAGES-1];
	assign out_quot = quot_s[STAGES-1];

endmodule

[src/evg_cordic.sv]
// Pipelined rotation-mode CORDIC with quarter-turn folding, one step per stage.
module evg_cordic #(
	parameter int ANGLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  evg_pkg::evg_tag_t                   in_tag,
	input  logic [ANGLE_BITS-1:0]               in_angle,
	output evg_pkg::evg_tag_t                   out_tag,
	output logic signed [evg_pkg::TRIG_W-1:0]   out_cos,
	output logic signed [evg_pkg::TRIG_W-1:0]   out_sin
);
	import evg_pkg::*;

	localparam int ANG_SHIFT = TURN_W - ANGLE_BITS;
	localparam int STAGES    = CORDIC_STEPS + 1;

	evg_tag_t                tag_s [STAGES];
	logic signed [XY_W-1:0]  x_s   [STAGES];
	logic signed [XY_W-1:0]  y_s   [STAGES];
	logic [TURN_W-1:0]       z_s   [STAGES];
	evg_quad_t               qd_s  [STAGES];

	logic signed [XY_W-1:0]  x_nx [CORDIC_STEPS];
	logic signed [XY_W-1:0]  y_nx [CORDIC_STEPS];
	logic [TURN_W-1:0]       z_nx [CORDIC_STEPS];

	logic [TURN_W-1:0] ang;
	logic [1:0]        qd_raw;
	logic [TURN_W-1:0] z_init;

	evg_tag_t                tag_o_s;
	logic signed [TRIG_W-1:0] cos_o_s;
	logic signed [TRIG_W-1:0] sin_o_s;
	logic signed [TRIG_W-1:0] cos_nx;
	logic signed [TRIG_W-1:0] sin_nx;

	always_comb begin
		ang    = TURN_W'(in_angle) << ANG_SHIFT;
		qd_raw = ang[TURN_W-1:TURN_W-2] + 2'(ang[TURN_W-3]);
		z_init = ang - {qd_raw, {(TURN_W-2){1'b0}}};
	end

	always_comb begin
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (z_s[k][TURN_W-1]) begin
				x_nx[k] = x_s[k] + (y_s[k] >>> k);
				y_nx[k] = y_s[k] - (x_s[k] >>> k);
				z_nx[k] = z_s[k] + ATAN_TURNS[k];
			end else begin
				x_nx[k] = x_s[k] - (y_s[k] >>> k);
				y_nx[k] = y_s[k] + (x_s[k] >>> k);
				z_nx[k] = z_s[k] - ATAN_TURNS[k];
			end
		end
	end

	always_comb begin
		case (qd_s[CORDIC_STEPS])
			QUAD_EAST: begin
				cos_nx = TRIG_W'(x_s[CORDIC_STEPS]);
				sin_nx = TRIG_W'(y_s[CORDIC_STEPS]);
			end
			QUAD_NORTH: begin
				cos_nx = TRIG_W'(-y_s[CORDIC_STEPS]);
				sin_nx = TRIG_W'(x_s[CORDIC_STEPS]);
			end
			QUAD_WEST: begin
				cos_nx = TRIG_W'(-x_s[CORDIC_STEPS]);
				sin_nx = TRIG_W'(-y_s[CORDIC_STEPS]);
			end
			default: begin
				cos_nx = TRIG_W'(y_s[CORDIC_STEPS]);
				sin_nx = TRIG_W'(-x_s[CORDIC_STEPS]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				tag_s[k] <= '0;
			end
			tag_o_s <= '0;
		end else begin
			tag_s[0] <= in_tag;
			for (int k = 1; k < STAGES; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
			tag_o_s <= tag_s[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]  <= CORDIC_GAIN;
		y_s[0]  <= '0;
		z_s[0]  <= z_init;
		qd_s[0] <= evg_quad_t'(qd_raw);
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			x_s[k+1]  <= x_nx[k];
			y_s[k+1]  <= y_nx[k];
			z_s[k+1]  <= z_nx[k];
			qd_s[k+1] <= qd_s[k];
		end
		cos_o_s <= cos_nx;
		sin_o_s <= sin_nx;
	end

	assign out_tag = tag_o_s;
	assign out_cos = cos_o_s;
	assign out_sin = sin_o_s;

endmodule

[src/ellipse_vertex_generator.sv]
// Top level of the ellipse vertex generator: register file, pipeline and output stage.
//
// Usage:
//   Input channel: an item (vertex_index) is taken at a rising edge where start is high
//   and busy is low. busy stays low, so an item may enter in every cycle.
//   Result channel: done is high for one cycle with point_x, point_y, point_z and
//   index_error; the receiver cannot hold results off and none is needed.
//   Throughput: one item per cycle. The pipeline is made of the input register, the divider
//   (ANGLE_BITS + 1 stages, one quotient bit each), the CORDIC (one step per stage plus
//   folding stages) and the multiply, round and saturate stages.
//   Configuration: APB-style writes at byte address 4*i; reads return the register.
//   Write registers only while no item is in flight.
//   Reset: registers return to centre 0, radii 1.0 and 0.5, 21 vertices; all items
//   in flight are dropped.
module ellipse_vertex_generator #(
	parameter int MAX_VERTS  = 1024,
	parameter int ANGLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [evg_pkg::ADDR_W-1:0]           paddr,
	input  logic [evg_pkg::DATA_W-1:0]           pwdata,
	output logic [evg_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [evg_pkg::IDX_W-1:0]            vertex_index,
	output logic                                 done,
	output logic signed [evg_pkg::COORD_W-1:0]   point_x,
	output logic signed [evg_pkg::COORD_W-1:0]   point_y,
	output logic signed [evg_pkg::COORD_W-1:0]   point_z,
	output logic                                 index_error
);
	import evg_pkg::*;

	localparam int LATENCY = 1 + (ANGLE_BITS + 1) + (CORDIC_STEPS + 2) + 3;
	localparam int PROD_W  = 2 * TRIG_W;
	localparam int RND_W   = COORD_W + 2;
	localparam int FRAC_SH = 30;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_SH - 1));

	logic signed [COORD_W-1:0] center_x_q;
	logic signed [COORD_W-1:0] center_y_q;
	logic signed [COORD_W-1:0] center_z_q;
	logic [RAD_W-1:0]          major_radius_q;
	logic [RAD_W-1:0]          minor_radius_q;
	logic [CNT_W-1:0]          vertex_count_q;

	logic     cfg_wr;
	evg_reg_t cfg_sel;

	logic             accept;
	logic [CNT_W-1:0] n_eff;
	evg_tag_t         tag_nx;

	evg_tag_t         tag_s1;
	logic [IDX_W-1:0] index_s1;
	logic [CNT_W-1:0] div_s1;

	evg_tag_t              dv_tag;
	logic [ANGLE_BITS-1:0] dv_quot;
	logic [ANGLE_BITS-1:0] angle;

	evg_tag_t                 cr_tag;
	logic signed [TRIG_W-1:0] cr_cos;
	logic signed [TRIG_W-1:0] cr_sin;

	logic signed [TRIG_W-1:0] rad_x;
	logic signed [TRIG_W-1:0] rad_y;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;

	evg_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] prod_x_s2;
	logic signed [PROD_W-1:0] prod_y_s2;

	evg_tag_t                tag_s3;
	logic signed [RND_W-1:0] round_x_s3;
	logic signed [RND_W-1:0] round_y_s3;

	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;

	logic                      done_s4;
	logic                      err_s4;
	logic signed [COORD_W-1:0] point_x_s4;
	logic signed [COORD_W-1:0] point_y_s4;
	logic signed [COORD_W-1:0] point_z_s4;

	// register file
	assign pready  = 1'b1;
	assign cfg_sel = evg_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= '0;
			center_y_q     <= '0;
			center_z_q     <= '0;
			major_radius_q <= MAJOR_RESET;
			minor_radius_q <= MINOR_RESET;
			vertex_count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_CENTER_X:     center_x_q     <= pwdata[COORD_W-1:0];
				REG_CENTER_Y:     center_y_q     <= pwdata[COORD_W-1:0];
				REG_CENTER_Z:     center_z_q     <= pwdata[COORD_W-1:0];
				REG_MAJOR_RADIUS: major_radius_q <= pwdata[RAD_W-1:0];
				REG_MINOR_RADIUS: minor_radius_q <= pwdata[RAD_W-1:0];
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_CENTER_X:     prdata = DATA_W'(center_x_q);
			REG_CENTER_Y:     prdata = DATA_W'(center_y_q);
			REG_CENTER_Z:     prdata = DATA_W'(center_z_q);
			REG_MAJOR_RADIUS: prdata = DATA_W'(major_radius_q);
			REG_MINOR_RADIUS: prdata = DATA_W'(minor_radius_q);
			REG_VERTEX_COUNT: prdata = DATA_W'(vertex_count_q);
			default:          prdata = '0;
		endcase
	end

	// input stage
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		n_eff = (32'(vertex_count_q) > 32'(MAX_VERTS)) ? CNT_W'(MAX_VERTS) : vertex_count_q;
		tag_nx.valid    = accept;
		tag_nx.err      = (CNT_W'(vertex_index) >= n_eff);
		tag_nx.zero_ang = (n_eff == CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_nx;
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= vertex_index;
		div_s1   <= n_eff - CNT_W'(1);
	end

	evg_divider #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (tag_s1),
		.in_index (index_s1),
		.in_div   (div_s1),
		.out_tag  (dv_tag),
		.out_quot (dv_quot)
	);

	assign angle = dv_tag.zero_ang ? '0 : dv_quot;

	evg_cordic #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (dv_tag),
		.in_angle (angle),
		.out_tag  (cr_tag),
		.out_cos  (cr_cos),
		.out_sin  (cr_sin)
	);

	// scale, round, offset and saturate
	assign rad_x  = {1'b0, major_radius_q};
	assign rad_y  = {1'b0, minor_radius_q};
	assign prod_x = rad_x * cr_cos;
	assign prod_y = rad_y * cr_sin;

	assign sum_x = SUM_W'(center_x_q) + SUM_W'(round_x_s3);
	assign sum_y = SUM_W'(center_y_q) + SUM_W'(round_y_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			tag_s3  <= '0;
			done_s4 <= 1'b0;
		end else begin
			tag_s2  <= cr_tag;
			tag_s3  <= tag_s2;
			done_s4 <= tag_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s2  <= prod_x;
		prod_y_s2  <= prod_y;
		round_x_s3 <= RND_W'((prod_x_s2 + ROUND_HALF) >>> FRAC_SH);
		round_y_s3 <= RND_W'((prod_y_s2 + ROUND_HALF) >>> FRAC_SH);
		err_s4     <= tag_s3.err;
		point_x_s4 <= tag_s3.err ? '0 : saturate(sum_x);
		point_y_s4 <= tag_s3.err ? '0 : saturate(sum_y);
		point_z_s4 <= tag_s3.err ? '0 : center_z_q;
	end

	assign done        = done_s4;
	assign index_error = err_s4;
	assign point_x     = point_x_s4;
	assign point_y     = point_y_s4;
	assign point_z     = point_z_s4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item did not emerge after the pipeline latency");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (point_x == '0 && point_y == '0 && point_z == '0))
		else $error("out-of-range item gave non-zero coordinates");

endmodule

[tb/ellipse_vertex_generator_test.sv]
// Self-checking testbench for the ellipse vertex generator: directed table, then random phases.
`timescale 1ns / 100ps

module ellipse_vertex_generator_test;
	import evg_pkg::*;

	localparam int MAX_VERTS      = 1024;
	localparam int ANGLE_BITS     = 24;
	localparam int VERTEX_LATENCY = ANGLE_BITS + 35;
	localparam int ARC_STEPS      = 28;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 240;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [63:0] UNIT_GAIN = 64'h26DD3B6A;
	localparam logic [31:0] ARC_TURNS [ARC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               err;
	} vertex_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_no;
		logic [31:0] value;
		logic        typed;
		vertex_t     want;
	} plan_row_t;

	localparam vertex_t NO_CHECK     = '0;
	localparam vertex_t AT_ZERO      = '{32'sd65536, 32'sd0, 32'sd0, 1'b0};
	localparam vertex_t OUT_OF_RANGE = '{32'sd0, 32'sd0, 32'sd0, 1'b1};
	localparam vertex_t FLAT_CORNER  = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0};

	localparam int PLAN_LEN = 41;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_ITEM,  3'd0,             32'd0,        1'b1, AT_ZERO},
		'{ROW_ITEM,  3'd0,             32'd5,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd10,       1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd15,       1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd20,       1'b1, AT_ZERO},
		'{ROW_ITEM,  3'd0,             32'd21,       1'b1, OUT_OF_RANGE},
		'{ROW_ITEM,  3'd0,             32'd1023,     1'b1, OUT_OF_RANGE},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd0,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd0,        1'b1, OUT_OF_RANGE},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd1,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd0,        1'b1, AT_ZERO},
		'{ROW_ITEM,  3'd0,             32'd1,        1'b1, OUT_OF_RANGE},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'hFFFFFFFF, 1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd1023,     1'b0, NO_CHECK},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd1025,     1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd1023,     1'b0, NO_CHECK},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd1024,     1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd1023,     1'b0, NO_CHECK},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd2,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd0,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd1,        1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_X,     32'h7FFFFFFF, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_Y,     32'h80000000, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_Z,     32'h80000000, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_MAJOR_RADIUS, 32'hFFFFFFFF, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_MINOR_RADIUS, 32'h7FFFFFFF, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_VERTEX_COUNT, 32'd5,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd0,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd1,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd2,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd3,        1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd4,        1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_X,     32'h80000000, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_Y,     32'h7FFFFFFF, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_CENTER_Z,     32'h7FFFFFFF, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_MAJOR_RADIUS, 32'd0,        1'b0, NO_CHECK},
		'{ROW_WRITE, REG_MINOR_RADIUS, 32'd0,        1'b0, NO_CHECK},
		'{ROW_WRITE, REG_SPARE_LO,     32'h12345678, 1'b0, NO_CHECK},
		'{ROW_WRITE, REG_SPARE_HI,     32'hFFFFFFFF, 1'b0, NO_CHECK},
		'{ROW_ITEM,  3'd0,             32'd3,        1'b1, FLAT_CORNER},
		'{ROW_ITEM,  3'd0,             32'd5,        1'b1, OUT_OF_RANGE}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ADDR_W-1:0]           paddr;
	logic [DATA_W-1:0]           pwdata;
	logic [DATA_W-1:0]           prdata;
	logic                        pready;
	logic                        start;
	logic                        busy;
	logic [IDX_W-1:0]            vertex_index;
	logic                        done;
	logic signed [COORD_W-1:0]   point_x;
	logic signed [COORD_W-1:0]   point_y;
	logic signed [COORD_W-1:0]   point_z;
	logic                        index_error;

	logic signed [31:0] cfg_cx;
	logic signed [31:0] cfg_cy;
	logic signed [31:0] cfg_cz;
	logic [30:0]        cfg_major;
	logic [30:0]        cfg_minor;
	logic [10:0]        cfg_count;

	vertex_t expected_vertices [$];
	vertex_t arrived_want;
	int      mismatches;

	ellipse_vertex_generator #(
		.MAX_VERTS  (MAX_VERTS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.vertex_index (vertex_index),
		.done         (done),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.index_error  (index_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	function automatic logic signed [31:0] scale_add(input logic signed [31:0] center,
			input logic [30:0] radius, input logic signed [63:0] trig);
		logic signed [63:0] prod;
		logic signed [63:0] sum;
		logic signed [63:0] cen;
		cen  = center;
		prod = $signed({33'd0, radius}) * trig;
		sum  = cen + ((prod + 64'sd536870912) >>> 30);
		if (sum > 64'sh7FFFFFFF) begin
			scale_add = 32'sh7FFFFFFF;
		end else if (sum < -64'sh80000000) begin
			scale_add = 32'sh80000000;
		end else begin
			scale_add = sum[31:0];
		end
	endfunction

	function automatic vertex_t ellipse_point(input logic [IDX_W-1:0] idx);
		vertex_t            v;
		logic [10:0]        n;
		logic [63:0]        a;
		logic [63:0]        d;
		logic [63:0]        ang;
		logic [63:0]        nudged;
		logic [31:0]        resid;
		logic signed [63:0] px;
		logic signed [63:0] py;
		logic signed [63:0] pz;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [63:0] c;
		logic signed [63:0] s;
		evg_quad_t          quad;
		v = '0;
		n = (cfg_count > 11'(MAX_VERTS)) ? 11'(MAX_VERTS) : cfg_count;
		if ({1'b0, idx} >= n) begin
			v.err = 1'b1;
		end else begin
			a = '0;
			if (n > 11'd1) begin
				d = 64'(n) - 64'd1;
				a = ((64'(idx) << ANGLE_BITS) + (d >> 1)) / d;
				a = a & ((64'd1 << ANGLE_BITS) - 64'd1);
			end
			ang    = (a << (32 - ANGLE_BITS)) & 64'hFFFFFFFF;
			nudged = ang + 64'h20000000;
			quad   = evg_quad_t'(nudged[31:30]);
			resid  = ang[31:0] - {quad, 30'd0};
			pz     = {{32{resid[31]}}, resid};
			px     = UNIT_GAIN;
			py     = '0;
			for (int k = 0; k < ARC_STEPS; k++) begin
				dx = py >>> k;
				dy = px >>> k;
				if (pz < 0) begin
					px = px + dx;
					py = py - dy;
					pz = pz + $signed({32'd0, ARC_TURNS[k]});
				end else begin
					px = px - dx;
					py = py + dy;
					pz = pz - $signed({32'd0, ARC_TURNS[k]});
				end
			end
			case (quad)
				QUAD_EAST: begin
					c = px;
					s = py;
				end
				QUAD_NORTH: begin
					c = -py;
					s = px;
				end
				QUAD_WEST: begin
					c = -px;
					s = -py;
				end
				default: begin
					c = py;
					s = -px;
				end
			endcase
			v.x = scale_add(cfg_cx, cfg_major, c);
			v.y = scale_add(cfg_cy, cfg_minor, s);
			v.z = cfg_cz;
		end
		return v;
	endfunction

	function automatic logic [31:0] register_value(input logic [2:0] reg_no);
		case (reg_no)
			REG_CENTER_X:     register_value = cfg_cx;
			REG_CENTER_Y:     register_value = cfg_cy;
			REG_CENTER_Z:     register_value = cfg_cz;
			REG_MAJOR_RADIUS: register_value = {1'b0, cfg_major};
			REG_MINOR_RADIUS: register_value = {1'b0, cfg_minor};
			REG_VERTEX_COUNT: register_value = {21'd0, cfg_count};
			default:          register_value = '0;
		endcase
	endfunction

	task automatic apb_cycle(input logic wr, input logic [2:0] reg_no, input logic [31:0] data,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_no, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_register(input logic [2:0] reg_no);
		logic [31:0] rd;
		apb_cycle(1'b0, reg_no, $urandom, rd);
		if (rd !== register_value(reg_no))
			report_mismatch($sformatf("register %0d", reg_no), 64'(rd),
				64'(register_value(reg_no)));
	endtask

	task automatic config_write(input logic [2:0] reg_no, input logic [31:0] data);
		logic [31:0] rd;
		apb_cycle(1'b1, reg_no, data, rd);
		case (reg_no)
			REG_CENTER_X:     cfg_cx = data;
			REG_CENTER_Y:     cfg_cy = data;
			REG_CENTER_Z:     cfg_cz = data;
			REG_MAJOR_RADIUS: cfg_major = data[30:0];
			REG_MINOR_RADIUS: cfg_minor = data[30:0];
			REG_VERTEX_COUNT: cfg_count = data[10:0];
			default: ;
		endcase
		if (reg_no <= 3'(REG_VERTEX_COUNT))
			check_register(reg_no);
	endtask

	task automatic idle_cycle();
		@(negedge clk);
		start        <= 1'b0;
		vertex_index <= IDX_W'($urandom);
	endtask

	task automatic send_vertex(input logic [IDX_W-1:0] idx, input logic typed,
			input vertex_t want);
		@(negedge clk);
		start        <= 1'b1;
		vertex_index <= idx;
		do @(posedge clk); while (busy);
		expected_vertices.push_back(typed ? want : ellipse_point(idx));
	endtask

	task automatic wait_drained();
		while (expected_vertices.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_center();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h7FFFFFFF;
			1: v = 32'h80000000;
			2, 3: v = $urandom;
			default: begin
				v = $urandom & 32'h003FFFFF;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] random_radius();
		logic [30:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2, 3: v = 31'($urandom);
			default: v = 31'($urandom & 32'h00FFFFFF);
		endcase
		return {1'($urandom_range(0, 1)), v};
	endfunction

	function automatic logic [31:0] random_count();
		logic [10:0] n;
		case ($urandom_range(0, 15))
			0: n = 11'd0;
			1: n = 11'd1;
			2: n = 11'd2;
			3: n = 11'(MAX_VERTS);
			4: n = 11'(MAX_VERTS + 1);
			5: n = 11'h7FF;
			6, 7, 8, 9, 10: n = 11'($urandom_range(2, MAX_VERTS));
			default: n = 11'($urandom_range(2, 40));
		endcase
		return {21'($urandom), n};
	endfunction

	task automatic randomise_config();
		config_write(REG_CENTER_X, random_center());
		config_write(REG_CENTER_Y, random_center());
		config_write(REG_CENTER_Z, random_center());
		config_write(REG_MAJOR_RADIUS, random_radius());
		config_write(REG_MINOR_RADIUS, random_radius());
		config_write(REG_VERTEX_COUNT, random_count());
	endtask

	function automatic logic [IDX_W-1:0] random_index();
		int n_eff;
		int pick;
		n_eff = (cfg_count > 11'(MAX_VERTS)) ? MAX_VERTS : int'(cfg_count);
		pick  = $urandom_range(0, 99);
		if (n_eff == 0 || pick < 10)
			return IDX_W'($urandom);
		if (pick < 15)
			return IDX_W'(n_eff - 1);
		if (pick < 20)
			return '0;
		return IDX_W'($urandom_range(0, n_eff - 1));
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_vertices.size() == 0) begin
				report_mismatch("unexpected vertex", 64'(point_x), 64'd0);
			end else begin
				arrived_want = expected_vertices.pop_front();
				if (point_x !== arrived_want.x)
					report_mismatch("point_x", 64'(point_x), 64'(arrived_want.x));
				if (point_y !== arrived_want.y)
					report_mismatch("point_y", 64'(point_y), 64'(arrived_want.y));
				if (point_z !== arrived_want.z)
					report_mismatch("point_z", 64'(point_z), 64'(arrived_want.z));
				if (index_error !== arrived_want.err)
					report_mismatch("index_error", 64'(index_error), 64'(arrived_want.err));
			end
		end
	end

	initial begin
		int  pct;
		int  pct_now;
		logic burst;
		mismatches   = 0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		vertex_index = '0;
		cfg_cx       = '0;
		cfg_cy       = '0;
		cfg_cz       = '0;
		cfg_major    = MAJOR_RESET;
		cfg_minor    = MINOR_RESET;
		cfg_count    = COUNT_RESET;
		burst        = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r <= int'(REG_VERTEX_COUNT); r++)
			check_register(3'(r));

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				idle_cycle();
				wait_drained();
				config_write(PLAN[i].reg_no, PLAN[i].value);
			end else begin
				send_vertex(PLAN[i].value[IDX_W-1:0], PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_cycle();
			wait_drained();
			randomise_config();
			case (p % 3)
				0: pct = 0;
				1: pct = 76;
				default: pct = 35;
			endcase
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if (j % 32 == 0)
					burst = ($urandom_range(0, 3) == 0);
				pct_now = burst ? 0 : pct;
				while ($urandom_range(0, 99) < pct_now)
					idle_cycle();
				send_vertex(random_index(), 1'b0, NO_CHECK);
			end
		end

		// drop start, let the pipeline empty, then watch for strays
		idle_cycle();
		wait_drained();
		repeat (VERTEX_LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
